// File: hw/rtl/hee_pkg.sv
// shared types, character constants and the decimal digit step for the html entity escaper
// no dependencies; used by hee_format, hee_emit, hee_checker and html_entity_escaper
package hee_pkg;

  localparam int CHAR_W  = 16;
  localparam int RUN_MAX = 8;
  localparam int LEN_W   = 4;
  localparam int DIG_N   = 5;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [LEN_W-1:0]  len_t;

  // input codes that get special treatment
  localparam char_t CODE_NUL   = 16'd0;
  localparam char_t CODE_LF    = 16'd10;
  localparam char_t CODE_CR    = 16'd13;
  localparam char_t CODE_QUOT  = 16'd34;
  localparam char_t CODE_AMP   = 16'd38;
  localparam char_t CODE_LT    = 16'd60;
  localparam char_t CODE_GT    = 16'd62;
  localparam char_t ESCAPE_MIN = 16'd160;

  // ascii characters used in the escape sequences
  localparam char_t CH_AMP  = 16'd38;
  localparam char_t CH_HASH = 16'd35;
  localparam char_t CH_SEMI = 16'd59;
  localparam char_t CH_LT   = 16'd60;
  localparam char_t CH_GT   = 16'd62;
  localparam char_t CH_B    = 16'd98;
  localparam char_t CH_R    = 16'd114;
  localparam char_t CH_0    = 16'd48;

  // decimal place handled by each digit stage, most significant first
  localparam logic [16:0] PLACE [DIG_N-1] = '{17'd10000, 17'd1000, 17'd100, 17'd10};

  typedef struct packed {
    logic [3:0]  digit;
    logic [15:0] rem;
  } dsplit_t;

  // one item in the digit pipeline
  typedef struct packed {
    char_t                      code;
    logic [15:0]                rem;
    logic [DIG_N-2:0][3:0]      digs;
  } stage_t;

  // a complete output run, chars[0] goes out first
  typedef struct packed {
    logic [RUN_MAX-1:0][CHAR_W-1:0] chars;
    len_t                           len;
  } run_t;

  // take off one decimal digit by parallel compares against the multiples of place
  function automatic dsplit_t digit_step(input logic [15:0] val, input logic [16:0] place);
    dsplit_t     res;
    logic [16:0] mul;
    logic [16:0] sub;
    res.digit = '0;
    sub       = '0;
    for (int k = 1; k <= 9; k++) begin
      mul = 17'(k) * place;
      if ({1'b0, val} >= mul) begin
        res.digit = 4'(k);
        sub       = mul;
      end
    end
    res.rem = 16'({1'b0, val} - sub);
    return res;
  endfunction

endpackage

// File: hw/rtl/html_entity_escaper.sv
// html entity escaper: one 16-bit code in per transaction, its html-safe form out as a
// character run. A code is accepted on a clock edge with start high and busy low, and its
// run passes through the input register, the digit stages and the run buffer to out_valid/
// out_char/out_run_last, one character per cycle, with out_run_last on the final one; the
// receiver cannot stall. Line feed gives "<br>", carriage return and code 0 give no output,
// quote, ampersand, less-than, greater-than and codes of 160 or more give "&#<decimal>;".
// An item holds the single output port until its run (one to eight characters) is out, and
// still takes its turn there when it has no output, so a new code can be taken every cycle
// while runs are one character long. Depends on hee_pkg, hee_format and hee_emit.
module html_entity_escaper (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  hee_pkg::char_t in_char_code,
  output logic           out_valid,
  output hee_pkg::char_t out_char,
  output logic           out_run_last
);

  logic          take;
  logic          run_valid;
  hee_pkg::run_t run;

  hee_format u_format (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_code   (in_char_code),
    .busy      (busy),
    .take      (take),
    .run_valid (run_valid),
    .run       (run)
  );

  hee_emit u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .run_valid    (run_valid),
    .run          (run),
    .take         (take),
    .out_valid    (out_valid),
    .out_char     (out_char),
    .out_run_last (out_run_last)
  );

endmodule

// File: hw/rtl/hee_format.sv
// input register, decimal digit pipeline and run builder for the html entity escaper
// depends on hee_pkg; feeds hee_emit
module hee_format (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  hee_pkg::char_t in_code,
  output logic          busy,
  input  logic          take,
  output logic          run_valid,
  output hee_pkg::run_t run
);

  localparam int NSTG = hee_pkg::DIG_N;

  hee_pkg::stage_t stg_r   [NSTG];
  hee_pkg::stage_t stg_nxt [NSTG];
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] adv;
  logic            accept;

  // a stage moves on when the next one is empty or moving too
  always_comb begin
    adv[NSTG-1] = vld_r[NSTG-1] && take;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = vld_r[k] && (!vld_r[k+1] || adv[k+1]);
    end
  end

  assign busy   = vld_r[0] && !adv[0];
  assign accept = start && !busy;

  always_comb begin
    hee_pkg::dsplit_t split;
    vld_nxt[0]      = accept || (vld_r[0] && !adv[0]);
    stg_nxt[0].code = in_code;
    stg_nxt[0].rem  = in_code;
    stg_nxt[0].digs = '0;
    for (int k = 1; k < NSTG; k++) begin
      split           = hee_pkg::digit_step(stg_r[k-1].rem, hee_pkg::PLACE[k-1]);
      vld_nxt[k]      = adv[k-1] || (vld_r[k] && !adv[k]);
      stg_nxt[k]      = stg_r[k-1];
      stg_nxt[k].digs[k-1] = split.digit;
      stg_nxt[k].rem  = split.rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_r[0] <= stg_nxt[0];
    end
    for (int k = 1; k < NSTG; k++) begin
      if (adv[k-1]) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  // build the run from the last stage
  hee_pkg::char_t               code;
  logic [NSTG-1:0][3:0]         dd;
  logic [2:0]                   ndig;

  assign code = stg_r[NSTG-1].code;
  // dd[0] holds the ten-thousands digit, dd[4] the ones digit
  assign dd   = {stg_r[NSTG-1].rem[3:0], stg_r[NSTG-1].digs[3], stg_r[NSTG-1].digs[2],
                 stg_r[NSTG-1].digs[1], stg_r[NSTG-1].digs[0]};

  always_comb begin
    if (code >= 16'd10000)     ndig = 3'd5;
    else if (code >= 16'd1000) ndig = 3'd4;
    else if (code >= 16'd100)  ndig = 3'd3;
    else if (code >= 16'd10)   ndig = 3'd2;
    else                       ndig = 3'd1;
  end

  always_comb begin
    logic [2:0] sel;
    run.chars = '0;
    run.len   = '0;
    sel       = '0;
    case (code) inside
      hee_pkg::CODE_NUL, hee_pkg::CODE_CR: begin
        run.len = '0;
      end
      hee_pkg::CODE_LF: begin
        run.chars[0] = hee_pkg::CH_LT;
        run.chars[1] = hee_pkg::CH_B;
        run.chars[2] = hee_pkg::CH_R;
        run.chars[3] = hee_pkg::CH_GT;
        run.len      = 4'd4;
      end
      hee_pkg::CODE_QUOT, hee_pkg::CODE_AMP, hee_pkg::CODE_LT, hee_pkg::CODE_GT,
      [hee_pkg::ESCAPE_MIN : 16'hFFFF]: begin
        run.chars[0] = hee_pkg::CH_AMP;
        run.chars[1] = hee_pkg::CH_HASH;
        for (int p = 0; p < hee_pkg::RUN_MAX - 2; p++) begin
          if (3'(p) < ndig) begin
            // skip leading zeros: first digit taken is at 5 - ndig
            sel            = 3'(hee_pkg::DIG_N) - ndig + 3'(p);
            run.chars[2+p] = hee_pkg::CH_0 + {12'd0, dd[sel]};
          end else if (3'(p) == ndig) begin
            run.chars[2+p] = hee_pkg::CH_SEMI;
          end
        end
        run.len = {1'b0, ndig} + 4'd3;
      end
      default: begin
        run.chars[0] = code;
        run.len      = 4'd1;
      end
    endcase
  end

  assign run_valid = vld_r[NSTG-1];

endmodule

// File: hw/rtl/hee_emit.sv
// run buffer that sends one character of the current run per cycle
// depends on hee_pkg; loaded from hee_format
module hee_emit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           run_valid,
  input  hee_pkg::run_t  run,
  output logic           take,
  output logic           out_valid,
  output hee_pkg::char_t out_char,
  output logic           out_run_last
);

  logic [hee_pkg::RUN_MAX-1:0][hee_pkg::CHAR_W-1:0] chars_r;
  logic [hee_pkg::RUN_MAX-1:0][hee_pkg::CHAR_W-1:0] chars_nxt;
  hee_pkg::len_t left_r;
  hee_pkg::len_t left_nxt;

  // free when empty or on the last character of the current run
  assign take = (left_r <= 4'd1);

  always_comb begin
    if (take) begin
      chars_nxt = run.chars;
      left_nxt  = run_valid ? run.len : '0;
    end else begin
      chars_nxt = {{hee_pkg::CHAR_W{1'b0}}, chars_r[hee_pkg::RUN_MAX-1:1]};
      left_nxt  = left_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else begin
      left_r <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chars_r <= chars_nxt;
  end

  assign out_valid    = (left_r != '0);
  assign out_char     = chars_r[0];
  assign out_run_last = (left_r == 4'd1);

endmodule

// File: hw/rtl/hee_checker.sv
// port-level checks for the html entity escaper, bound to the top level
// depends on hee_pkg and html_entity_escaper
module hee_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input hee_pkg::char_t in_char_code,
  input logic           out_valid,
  input hee_pkg::char_t out_char,
  input logic           out_run_last
);

  // an accepted transaction carries a known code
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> !$isunknown(in_char_code))
    else $error("unknown code accepted");

  // a run goes out without gaps until its last character
  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_run_last |=> out_valid)
    else $error("run interrupted before its last character");

  a_last_needs_valid: assert property (@(posedge clk)
    !out_valid |-> !out_run_last)
    else $error("run_last without a valid character");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("block not idle after reset");

  // an ampersand inside a run always opens a numeric reference
  a_amp_then_hash: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_run_last && out_char == hee_pkg::CH_AMP |=>
      out_char == hee_pkg::CH_HASH)
    else $error("ampersand not followed by hash");

endmodule

bind html_entity_escaper hee_checker u_hee_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_char_code (in_char_code),
  .out_valid    (out_valid),
  .out_char     (out_char),
  .out_run_last (out_run_last)
);
